// ----- rtl/prpf_pkg.sv -----
// Shared constants for the polyline redundant point filter.
// No dependencies; imported by polyline_redundant_point_filter_unit.
package prpf_pkg;

	localparam int COORD_BITS_DEF = 29;
	localparam int INDEX_BITS_DEF = 16;
	localparam int THR_BITS       = 16;
	localparam int KEPT_BITS      = 2;
	localparam logic [KEPT_BITS-1:0] KEPT_SAT = 2'd3;
	localparam int OP_BITS        = 5;
	localparam int CROSS_LIMIT    = 49;

	// Micro-operations of the shared multiplier
	localparam logic [OP_BITS-1:0] OP_T2   = 5'd0;
	localparam logic [OP_BITS-1:0] OP_DXX  = 5'd1;
	localparam logic [OP_BITS-1:0] OP_DYY  = 5'd2;
	localparam logic [OP_BITS-1:0] OP_WXDX = 5'd3;
	localparam logic [OP_BITS-1:0] OP_WYDY = 5'd4;
	localparam logic [OP_BITS-1:0] OP_WXWX = 5'd5;
	localparam logic [OP_BITS-1:0] OP_WYWY = 5'd6;
	localparam logic [OP_BITS-1:0] OP_EXEX = 5'd7;
	localparam logic [OP_BITS-1:0] OP_EYEY = 5'd8;
	localparam logic [OP_BITS-1:0] OP_WXDY = 5'd9;
	localparam logic [OP_BITS-1:0] OP_WYDX = 5'd10;
	localparam logic [OP_BITS-1:0] OP_CLL  = 5'd11;
	localparam logic [OP_BITS-1:0] OP_CLH  = 5'd12;
	localparam logic [OP_BITS-1:0] OP_CHL  = 5'd13;
	localparam logic [OP_BITS-1:0] OP_CHH  = 5'd14;
	localparam logic [OP_BITS-1:0] OP_LLO  = 5'd15;
	localparam logic [OP_BITS-1:0] OP_LHI  = 5'd16;

	// Shift codes for the product into the accumulator
	localparam logic [1:0] SH_0 = 2'd0;
	localparam logic [1:0] SH_1 = 2'd1;
	localparam logic [1:0] SH_2 = 2'd2;

endpackage

// ----- rtl/polyline_redundant_point_filter_unit.sv -----
// Polyline redundant point filter: one-pass perpendicular distance test on ring nodes.
// Depends on prpf_pkg for constants and micro-operation codes.
//
// Nodes of a closed ring enter one transaction at a time; each decided node leaves as a
// result (index in tdata, keep and revert flags in tuser, ring end in tlast). A node that
// needs a distance test runs a sequence of products on one shared multiplier, each product
// in a multiply state and then an accumulate state; the node is then decided, its results
// are loaded into the output register one by one, and the block returns to idle. A node
// without a test skips the products. The input is
// not ready until the results of the previous node are in the output register. The
// threshold may be written at any time the block is idle.
module polyline_redundant_point_filter_unit #(
	parameter int COORD_BITS = prpf_pkg::COORD_BITS_DEF,
	parameter int INDEX_BITS = prpf_pkg::INDEX_BITS_DEF,
	localparam int IN_W  = ((2*COORD_BITS+7)/8)*8,
	localparam int OUT_W = ((INDEX_BITS+7)/8)*8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,  // node_lon, node_lat, zero fill
	input  logic [1:0]                    s_tuser,  // node_unshared, ring_first
	input  logic                          s_tlast,  // ring_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OUT_W-1:0]              m_tdata,  // node_index, zero fill
	output logic [1:0]                    m_tuser,  // keep, revert_all
	output logic                          m_tlast,  // ring_done
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [prpf_pkg::THR_BITS-1:0] cfg_data  // distance_threshold
);
	import prpf_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int MW = (COORD_BITS + 2 > 2*THR_BITS) ? COORD_BITS + 2 : 2*THR_BITS;
	localparam int LW = 2*MW + 1;
	localparam int AW = 4*MW + 2;
	localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                   state_q;
	logic [OP_BITS-1:0]           op_q;
	logic [THR_BITS-1:0]          thr_q;
	logic signed [COORD_BITS-1:0] lon_q, lat_q;
	logic                         uns_q, last_q;
	logic signed [COORD_BITS-1:0] anchor_lon_q, anchor_lat_q, cand_lon_q, cand_lat_q;
	logic                         cand_uns_q;
	logic [INDEX_BITS-1:0]        pos_q;
	logic                         removed_q;
	logic [KEPT_BITS-1:0]         kept_q;
	logic [2*MW-1:0]              p_q;
	logic                         pneg_q, pclr_q;
	logic [1:0]                   psh_q;
	logic signed [AW-1:0]         acc_q;
	logic [2*THR_BITS-1:0]        t2_q;
	logic [LW-1:0]                len2_q;
	logic [LW-1:0]                cmag_q;
	logic                         close_q;
	logic                         r0v_q, r1v_q;
	logic [INDEX_BITS-1:0]        r0_idx_q, r1_idx_q;
	logic                         r0_keep_q, r1_keep_q, r1_done_q, r1_rev_q;
	logic                         out_valid_q;
	logic [INDEX_BITS-1:0]        out_idx_q;
	logic                         out_keep_q, out_done_q, out_rev_q;

	// Differences from anchor, to the new node and between candidate and new node
	logic signed [DW-1:0] wx, wy, dx, dy, ex, ey;
	logic [DW-1:0]        wxm, wym, dxm, dym, exm, eym;

	assign wx = {cand_lon_q[COORD_BITS-1], cand_lon_q} - {anchor_lon_q[COORD_BITS-1], anchor_lon_q};
	assign wy = {cand_lat_q[COORD_BITS-1], cand_lat_q} - {anchor_lat_q[COORD_BITS-1], anchor_lat_q};
	assign dx = {lon_q[COORD_BITS-1], lon_q} - {anchor_lon_q[COORD_BITS-1], anchor_lon_q};
	assign dy = {lat_q[COORD_BITS-1], lat_q} - {anchor_lat_q[COORD_BITS-1], anchor_lat_q};
	assign ex = {cand_lon_q[COORD_BITS-1], cand_lon_q} - {lon_q[COORD_BITS-1], lon_q};
	assign ey = {cand_lat_q[COORD_BITS-1], cand_lat_q} - {lat_q[COORD_BITS-1], lat_q};
	assign wxm = wx[DW-1] ? DW'(-wx) : DW'(wx);
	assign wym = wy[DW-1] ? DW'(-wy) : DW'(wy);
	assign dxm = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign dym = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign exm = ex[DW-1] ? DW'(-ex) : DW'(ex);
	assign eym = ey[DW-1] ? DW'(-ey) : DW'(ey);

	// Select operands of the shared multiplier for the current micro-operation
	logic [MW-1:0] op_a, op_b;
	logic          op_neg, op_clr;
	logic [1:0]    op_sh;

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_neg = 1'b0;
		op_clr = 1'b0;
		op_sh  = SH_0;
		case (op_q)
			OP_T2: begin
				op_a = MW'(thr_q); op_b = MW'(thr_q); op_clr = 1'b1;
			end
			OP_DXX: begin
				op_a = MW'(dxm); op_b = MW'(dxm); op_clr = 1'b1;
			end
			OP_DYY: begin
				op_a = MW'(dym); op_b = MW'(dym);
			end
			OP_WXDX: begin
				op_a = MW'(wxm); op_b = MW'(dxm); op_clr = 1'b1;
				op_neg = wx[DW-1] ^ dx[DW-1];
			end
			OP_WYDY: begin
				op_a = MW'(wym); op_b = MW'(dym);
				op_neg = wy[DW-1] ^ dy[DW-1];
			end
			OP_WXWX: begin
				op_a = MW'(wxm); op_b = MW'(wxm); op_clr = 1'b1;
			end
			OP_WYWY: begin
				op_a = MW'(wym); op_b = MW'(wym);
			end
			OP_EXEX: begin
				op_a = MW'(exm); op_b = MW'(exm); op_clr = 1'b1;
			end
			OP_EYEY: begin
				op_a = MW'(eym); op_b = MW'(eym);
			end
			OP_WXDY: begin
				op_a = MW'(wxm); op_b = MW'(dym); op_clr = 1'b1;
				op_neg = wx[DW-1] ^ dy[DW-1];
			end
			OP_WYDX: begin
				op_a = MW'(wym); op_b = MW'(dxm);
				op_neg = ~(wy[DW-1] ^ dx[DW-1]);
			end
			OP_CLL: begin
				op_a = cmag_q[MW-1:0]; op_b = cmag_q[MW-1:0]; op_clr = 1'b1;
			end
			OP_CLH, OP_CHL: begin
				op_a = cmag_q[MW-1:0]; op_b = cmag_q[2*MW-1:MW]; op_sh = SH_1;
			end
			OP_CHH: begin
				op_a = cmag_q[2*MW-1:MW]; op_b = cmag_q[2*MW-1:MW]; op_sh = SH_2;
			end
			OP_LLO: begin
				op_a = len2_q[MW-1:0]; op_b = MW'(t2_q); op_neg = 1'b1;
			end
			OP_LHI: begin
				op_a = len2_q[2*MW-1:MW]; op_b = MW'(t2_q); op_neg = 1'b1; op_sh = SH_1;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	// Accumulate the registered product, shifted into place
	logic signed [AW-1:0] term, base, acc_next;
	logic [AW-1:0]        acc_mag;

	always_comb begin
		case (psh_q)
			SH_1:    term = AW'(p_q) << MW;
			SH_2:    term = AW'(p_q) << (2*MW);
			default: term = AW'(p_q);
		endcase
		base     = pclr_q ? '0 : acc_q;
		acc_next = pneg_q ? base - term : base + term;
		acc_mag  = acc_next[AW-1] ? AW'(-acc_next) : AW'(acc_next);
	end

	// Decision bookkeeping once the candidate test is settled
	logic                  do_dec, drop, rem_n;
	logic [KEPT_BITS-1:0]  kept1, kept2;
	logic [INDEX_BITS-1:0] next_idx;

	always_comb begin
		do_dec   = pos_q != '0;
		drop     = do_dec && close_q;
		rem_n    = removed_q | drop;
		kept1    = (do_dec && !drop && kept_q != KEPT_SAT) ? kept_q + 1'b1 : kept_q;
		kept2    = (kept1 != KEPT_SAT) ? kept1 + 1'b1 : kept1;
		next_idx = (pos_q != IDX_MAX) ? pos_q + 1'b1 : pos_q;
	end

	logic in_hs, first_in, out_load;
	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign in_hs     = s_tvalid && s_tready;
	assign first_in  = s_tuser[1] || kept_q == '0;
	assign out_load  = state_q == ST_EMIT && (r0v_q || r1v_q) && (!out_valid_q || m_tready);

	// Sequencer and ring control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_T2;
			thr_q       <= THR_BITS'(1);
			kept_q      <= '0;
			pos_q       <= '0;
			removed_q   <= 1'b0;
			cand_uns_q  <= 1'b0;
			r0v_q       <= 1'b0;
			r1v_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_hs) begin
						if (first_in) begin
							kept_q     <= s_tlast ? '0 : KEPT_BITS'(1);
							pos_q      <= '0;
							removed_q  <= 1'b0;
							cand_uns_q <= 1'b0;
							r0v_q      <= 1'b0;
							r1v_q      <= 1'b1;
							state_q    <= ST_EMIT;
						end else if (pos_q != '0 && cand_uns_q) begin
							op_q    <= OP_T2;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_MUL;
					op_q    <= op_q + 1'b1;
					case (op_q)
						OP_WYDY: begin
							if (len2_q == '0 || acc_next[AW-1] || acc_next == '0) begin
								op_q <= OP_WXWX;
							end else if (acc_next >= $signed(AW'(len2_q))) begin
								op_q <= OP_EXEX;
							end else begin
								op_q <= OP_WXDY;
							end
						end
						OP_WYWY, OP_EYEY, OP_LHI: begin
							state_q <= ST_FIN;
						end
						OP_WYDX: begin
							if (acc_mag[AW-1:CROSS_LIMIT] != '0) begin
								state_q <= ST_FIN;
							end
						end
						default: begin
							op_q <= op_q + 1'b1;
						end
					endcase
				end
				ST_FIN: begin
					r0v_q <= do_dec;
					if (last_q) begin
						r1v_q      <= 1'b1;
						kept_q     <= '0;
						pos_q      <= '0;
						removed_q  <= 1'b0;
						cand_uns_q <= 1'b0;
					end else begin
						r1v_q      <= 1'b0;
						kept_q     <= kept1;
						pos_q      <= next_idx;
						removed_q  <= rem_n;
						cand_uns_q <= uns_q;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						if (r0v_q) begin
							r0v_q <= 1'b0;
						end else begin
							r1v_q <= 1'b0;
						end
					end else if (!r0v_q && !r1v_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: captured node, anchor, candidate, products and results
	always_ff @(posedge clk) begin
		if (in_hs) begin
			lon_q  <= s_tdata[COORD_BITS-1:0];
			lat_q  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			uns_q  <= s_tuser[0];
			last_q <= s_tlast;
			if (first_in) begin
				anchor_lon_q <= s_tdata[COORD_BITS-1:0];
				anchor_lat_q <= s_tdata[2*COORD_BITS-1:COORD_BITS];
				cand_lon_q   <= '0;
				cand_lat_q   <= '0;
				r1_idx_q     <= '0;
				r1_keep_q    <= 1'b1;
				r1_done_q    <= s_tlast;
				r1_rev_q     <= 1'b0;
			end else begin
				close_q <= 1'b0;
			end
		end
		if (state_q == ST_MUL) begin
			p_q    <= op_a * op_b;
			pneg_q <= op_neg;
			pclr_q <= op_clr;
			psh_q  <= op_sh;
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_next;
			case (op_q)
				OP_T2:   t2_q   <= acc_next[2*THR_BITS-1:0];
				OP_DYY:  len2_q <= acc_next[LW-1:0];
				OP_WYWY, OP_EYEY: close_q <= acc_next < $signed(AW'(t2_q));
				OP_WYDX: begin
					cmag_q  <= acc_mag[LW-1:0];
					close_q <= 1'b0;
				end
				OP_LHI:  close_q <= acc_next[AW-1];
				default: close_q <= close_q;
			endcase
		end
		if (state_q == ST_FIN) begin
			r0_idx_q  <= pos_q;
			r0_keep_q <= !drop;
			if (do_dec && !drop) begin
				anchor_lon_q <= cand_lon_q;
				anchor_lat_q <= cand_lat_q;
			end
			r1_idx_q  <= next_idx;
			r1_keep_q <= 1'b1;
			r1_done_q <= 1'b1;
			r1_rev_q  <= rem_n && kept2 != KEPT_SAT;
			if (last_q) begin
				cand_lon_q <= '0;
				cand_lat_q <= '0;
			end else begin
				cand_lon_q <= lon_q;
				cand_lat_q <= lat_q;
			end
		end
		if (out_load) begin
			if (r0v_q) begin
				out_idx_q  <= r0_idx_q;
				out_keep_q <= r0_keep_q;
				out_done_q <= 1'b0;
				out_rev_q  <= 1'b0;
			end else begin
				out_idx_q  <= r1_idx_q;
				out_keep_q <= r1_keep_q;
				out_done_q <= r1_done_q;
				out_rev_q  <= r1_rev_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_idx_q);
	assign m_tuser  = {out_rev_q, out_keep_q};
	assign m_tlast  = out_done_q;

	// A revert flag only ever rides on the ring's final result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("revert flagged on a result that does not close a ring");

	// Once a node is taken, the input stays closed for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_hs |=> !s_tready)
		else $error("input reopened directly after a transaction");

	// The sequencer never runs past the last micro-operation
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_ACC) |-> op_q <= OP_LHI)
		else $error("micro-operation counter out of range");

	// A new result is only loaded when the output register is free or draining
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("output overwritten while stalled");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for polyline_redundant_point_filter_unit.
// Predicts ring node keep/drop decisions in-line and checks every result transaction.
// Depends on prpf_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;

	localparam int CW = prpf_pkg::COORD_BITS_DEF;
	localparam int IW = prpf_pkg::INDEX_BITS_DEF;
	localparam int IN_W = ((2*CW+7)/8)*8;
	localparam int OUT_W = ((IW+7)/8)*8;
	localparam logic [IW-1:0] IDX_MAX = '1;

	typedef struct packed {
		logic signed [CW-1:0] lon;
		logic signed [CW-1:0] lat;
		logic unshared;
		logic first;
		logic last;
	} node_t;

	typedef struct packed {
		logic [IW-1:0] idx;
		logic keep;
		logic done;
		logic revert;
	} decision_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	polyline_redundant_point_filter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor state
	logic [15:0] thr = 16'd1;
	logic signed [CW-1:0] anc_lon, anc_lat, cnd_lon, cnd_lat;
	logic cnd_uns, removed_any;
	logic [IW-1:0] ring_pos;
	logic [1:0] kept;
	decision_t expected_decisions[$];
	node_t pending_nodes[$];
	int mismatches = 0;
	int decisions_seen = 0;
	int send_idle = 0, recv_stall = 0;
	bit hold_req = 1'b0, hold_ack = 1'b0;
	int hold_cycles = 0;

	// Append to the tail of the result and node queues
	task automatic add_expected(decision_t d);
		expected_decisions.insert(expected_decisions.size(), d);
	endtask

	task automatic add_node(node_t n);
		pending_nodes.insert(pending_nodes.size(), n);
	endtask

	function automatic logic [127:0] sq(logic signed [127:0] v);
		return v * v;
	endfunction

	// True when the candidate sits strictly closer than thr to anchor..b
	function automatic bit near_segment(logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
		logic signed [127:0] wx, wy, dx, dy, ex, ey, dot, len2, crs, t2;
		wx = 128'(cnd_lon) - 128'(anc_lon);
		wy = 128'(cnd_lat) - 128'(anc_lat);
		dx = 128'(bx) - 128'(anc_lon);
		dy = 128'(by) - 128'(anc_lat);
		t2 = 128'(thr) * 128'(thr);
		len2 = dx*dx + dy*dy;
		dot = wx*dx + wy*dy;
		if (len2 == 0 || dot <= 0) return (wx*wx + wy*wy) < t2;
		if (dot >= len2) begin
			ex = 128'(cnd_lon) - 128'(bx);
			ey = 128'(cnd_lat) - 128'(by);
			return (ex*ex + ey*ey) < t2;
		end
		crs = wx*dy - wy*dx;
		if (crs < 0) crs = -crs;
		return sq(crs) < (len2 * t2);
	endfunction

	task automatic predict_node(node_t n);
		logic [IW-1:0] nxt;
		if (n.first || kept == 0) begin
			anc_lon = n.lon; anc_lat = n.lat;
			cnd_lon = '0; cnd_lat = '0; cnd_uns = 1'b0;
			ring_pos = '0; removed_any = 1'b0;
			add_expected(decision_t'{'0, 1'b1, n.last, 1'b0});
			kept = n.last ? 2'd0 : 2'd1;
			return;
		end
		nxt = (ring_pos < IDX_MAX) ? ring_pos + 1'b1 : IDX_MAX;
		if (ring_pos >= 1) begin
			if (cnd_uns && near_segment(n.lon, n.lat)) begin
				add_expected(decision_t'{ring_pos, 1'b0, 1'b0, 1'b0});
				removed_any = 1'b1;
			end else begin
				add_expected(decision_t'{ring_pos, 1'b1, 1'b0, 1'b0});
				anc_lon = cnd_lon; anc_lat = cnd_lat;
				if (kept < prpf_pkg::KEPT_SAT) kept++;
			end
		end
		if (n.last) begin
			if (kept < prpf_pkg::KEPT_SAT) kept++;
			add_expected(decision_t'{nxt, 1'b1, 1'b1,
				removed_any && kept < prpf_pkg::KEPT_SAT});
			kept = '0; ring_pos = '0; removed_any = 1'b0;
			cnd_lon = '0; cnd_lat = '0; cnd_uns = 1'b0;
		end else begin
			cnd_lon = n.lon; cnd_lat = n.lat; cnd_uns = n.unshared;
			ring_pos = nxt;
		end
	endtask

	task automatic report_mismatch(string what, decision_t got, decision_t exp);
		mismatches++;
		if (mismatches <= 20)
			$display("MISMATCH %s: got %0d/%0b/%0b/%0b exp %0d/%0b/%0b/%0b",
				what, got.idx, got.keep, got.done, got.revert,
				exp.idx, exp.keep, exp.done, exp.revert);
	endtask

	// Driver: advance the queue of nodes, idling at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_node(pending_nodes.pop_front());
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending_nodes.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_W'({pending_nodes[0].lat, pending_nodes[0].lon});
					s_tuser <= {pending_nodes[0].first, pending_nodes[0].unshared};
					s_tlast <= pending_nodes[0].last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stall counter for the long receiver hold-off
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= 400;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Monitor: check each result transaction, stall at random
	always @(posedge clk) begin
		decision_t got, exp;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[IW-1:0], m_tuser[0], m_tlast, m_tuser[1]};
				decisions_seen++;
				if (expected_decisions.size() == 0) begin
					report_mismatch("unexpected", got, got);
				end else begin
					exp = expected_decisions.pop_front();
					if (got != exp) report_mismatch("field", got, exp);
				end
			end
			m_tready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall);
		end
	end

	function automatic node_t make_node(int lon, int lat, bit u, bit f, bit l);
		return '{CW'(lon), CW'(lat), u, f, l};
	endfunction

	task automatic push_ring(int len, int spread);
		int x, y;
		x = $signed(CW'($urandom));
		y = $signed(CW'($urandom));
		for (int i = 0; i < len; i++) begin
			add_node(make_node(x, y, $urandom_range(9) != 0,
				i == 0, i == len - 1));
			x += $urandom_range(2*spread) - spread;
			y += $urandom_range(2*spread) - spread;
		end
	endtask

	task automatic drain();
		while (pending_nodes.size() > 0 || s_tvalid || expected_decisions.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		thr = v;
	endtask

	initial begin
		int sent;
		int lmin, lmax;
		kept = '0; ring_pos = '0; removed_any = 1'b0; cnd_uns = 1'b0;
		anc_lon = '0; anc_lat = '0; cnd_lon = '0; cnd_lat = '0;
		lmin = -(1 << (CW-1));
		lmax = (1 << (CW-1)) - 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: node with no open ring, singles, pairs, extremes, zero-length segment
		add_node(make_node(5, 5, 1, 0, 0));
		add_node(make_node(6, 5, 1, 0, 0));
		add_node(make_node(7, 5, 1, 0, 1));
		add_node(make_node(lmin, lmax, 1, 1, 1));
		add_node(make_node(lmax, lmin, 0, 1, 0));
		add_node(make_node(lmin, lmin, 1, 0, 1));
		add_node(make_node(0, 0, 1, 1, 0));
		add_node(make_node(0, 0, 1, 0, 0));
		add_node(make_node(0, 0, 1, 0, 0));
		add_node(make_node(lmax, lmax, 1, 0, 0));
		add_node(make_node(lmin, lmin, 1, 0, 0));
		add_node(make_node(lmax, lmin, 1, 1, 0));
		add_node(make_node(1, 1, 1, 0, 0));
		add_node(make_node(0, 0, 0, 0, 1));
		drain();

		// Large threshold with extreme coordinates; zero threshold on coincident nodes
		write_threshold(16'hFFFF);
		for (int i = 0; i < 8; i++)
			add_node(make_node(i[0] ? lmax : lmin, i[1] ? lmax : lmin,
				1, i == 0, i == 7));
		drain();
		write_threshold(16'd0);
		add_node(make_node(0, 0, 1, 1, 0));
		for (int i = 0; i < 6; i++)
			add_node(make_node(0, 0, 1, 0, i == 5));
		drain();

		// Random rings across idling phases and thresholds
		sent = 0;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 86; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 86; end
				3: begin send_idle = 23; recv_stall = 23; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			write_threshold(phase == 4 ? 16'd1 : 16'($urandom_range(1, 2000)));
			if (phase == 0) hold_req = ~hold_req;
			for (int r = 0; r < 40; r++) begin
				if ($urandom_range(9) == 0) begin
					add_node(make_node(int'($urandom), int'($urandom), 1'($urandom),
						1'($urandom), 1'($urandom)));
				end else begin
					push_ring($urandom_range(1, 12), $urandom_range(0, 3) == 0 ? 100000 : 3000);
				end
			end
			sent += pending_nodes.size();
			drain();
		end

		$display("Checked %0d decisions: directed ring shapes and %0d random nodes",
			decisions_seen, sent);
		$display("Thresholds 0, 1, 65535 and random; sender and receiver idling, one long stall.");
		if (mismatches == 0 && expected_decisions.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: end the run well after the slowest correct run
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
